// ----- hw/rtl/cbfd_pkg.sv -----
// shared types and constants for the can byte frame deframer
package cbfd_pkg;

    localparam int MAX_PAYLOAD = 64;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;

    localparam logic [6:0] POS_IDLE = 7'd0;
    localparam logic [6:0] POS_LEN  = 7'd5;
    localparam logic [6:0] POS_DATA = 7'd6;

    localparam logic [31:0] STD_ID_MAX = 32'h0000_07FF;

    localparam int TDATA_W = 80;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [5:0]  byte_index;
        logic        has_data;
        logic        last;
        logic [31:0] frame_id;
        logic        extended;
        logic [2:0]  comm_channel;
        logic [6:0]  source_node;
        logic [13:0] data_object_code;
        logic [1:0]  redundancy_channel;
        logic [6:0]  frame_length;
    } result_t;

endpackage

// ----- hw/rtl/cbfd_parser.sv -----
// frame position tracking, identifier capture and arinc 825 field decode
module cbfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        start_byte,
    output logic              res_valid,
    output cbfd_pkg::result_t res
);

    logic [6:0]  pos_reg, pos_next;
    logic [31:0] id_reg, id_next;
    logic [6:0]  len_reg, len_next;
    logic [5:0]  idx;
    logic        fin;

    assign idx = 6'(pos_reg - cbfd_pkg::POS_DATA);
    assign fin = ({1'b0, idx} + 7'd1) >= len_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        res_valid = 1'b0;

        res.payload_byte       = rx_byte;
        res.byte_index         = idx;
        res.has_data           = 1'b1;
        res.last               = fin;
        res.frame_id           = id_reg;
        res.extended           = id_reg > cbfd_pkg::STD_ID_MAX;
        res.comm_channel       = id_reg[28:26];
        res.source_node        = id_reg[25:19];
        res.data_object_code   = id_reg[18:5];
        res.redundancy_channel = id_reg[4:3];
        res.frame_length       = len_reg;

        if (step)
        begin
            if (pos_reg == cbfd_pkg::POS_IDLE)
            begin
                if (rx_byte == start_byte)
                    pos_next = 7'd1;
            end
            else if (pos_reg < cbfd_pkg::POS_LEN)
            begin
                // big-endian identifier, msb byte first
                id_next  = {id_reg[23:0], rx_byte};
                pos_next = pos_reg + 7'd1;
            end
            else if (pos_reg == cbfd_pkg::POS_LEN)
            begin
                if (rx_byte > 8'(cbfd_pkg::MAX_PAYLOAD))
                begin
                    pos_next = cbfd_pkg::POS_IDLE;
                end
                else
                begin
                    len_next = rx_byte[6:0];
                    if (rx_byte == 8'd0)
                    begin
                        // header-only word for an empty frame
                        pos_next           = cbfd_pkg::POS_IDLE;
                        res_valid          = 1'b1;
                        res.payload_byte   = 8'd0;
                        res.byte_index     = 6'd0;
                        res.has_data       = 1'b0;
                        res.last           = 1'b1;
                        res.frame_length   = 7'd0;
                    end
                    else
                    begin
                        pos_next = cbfd_pkg::POS_DATA;
                    end
                end
            end
            else
            begin
                res_valid = 1'b1;
                if (fin)
                    pos_next = cbfd_pkg::POS_IDLE;
                else
                    pos_next = pos_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= cbfd_pkg::POS_IDLE;
            id_reg  <= 32'd0;
            len_reg <= 7'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            id_reg  <= id_next;
            len_reg <= len_next;
        end
    end

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (pos_reg == cbfd_pkg::POS_IDLE))
        else $error("parser not idle after last word");

    a_result_only_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (step && pos_reg >= cbfd_pkg::POS_LEN))
        else $error("result outside length or payload phase");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.has_data) |-> (res.last && res.frame_length == 7'd0))
        else $error("header-only word not marked last");

endmodule

// ----- hw/rtl/cbfd_out_reg.sv -----
// result register on the master side of the stream
module cbfd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cbfd_pkg::result_t res,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              can_take,
    output cbfd_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    cbfd_pkg::result_t res_reg;

    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- hw/rtl/can_byte_frame_deframer_top.sv -----
// can byte frame deframer: input word register, parser and result register
// a result word passes through the input word register, the combinational parser and the result register
// throughput: one byte per cycle, set by the input register handing to the
//   result register each cycle while the master side keeps tready high
// reset: rst_n clears the parser to idle, empties both registers and loads
//   start byte 0xaa
module can_byte_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // payload_byte, byte_index, frame_id, extended, comm_channel, source_node,
    // data_object_code, redundancy_channel, frame_length
    output logic [cbfd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // has_data
);

    logic [7:0]        start_byte_reg;
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              step;
    logic              can_take;
    logic              res_valid;
    cbfd_pkg::result_t res;
    cbfd_pkg::result_t out_res;

    // a buffered byte moves on whenever the result register can take a word
    assign step          = in_valid_reg && can_take;
    assign s_axis_tready = !in_valid_reg || can_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            start_byte_reg <= cbfd_pkg::START_BYTE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en)
                start_byte_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    cbfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .start_byte (start_byte_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    cbfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .can_take  (can_take),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.frame_length, out_res.redundancy_channel,
                           out_res.data_object_code, out_res.source_node,
                           out_res.comm_channel, out_res.extended,
                           out_res.frame_id, out_res.byte_index,
                           out_res.payload_byte};
    assign m_axis_tlast = out_res.last;
    assign m_axis_tuser = out_res.has_data;

endmodule
